@@ hw/rtl/rtq_pkg.sv @@
// Shared types and constants for the reorderable tagged queue.
package rtq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [2:0] {
      CMD_ENQ   = 3'd0,
      CMD_REM   = 3'd1,
      CMD_UP    = 3'd2,
      CMD_DOWN  = 3'd3,
      CMD_CLEAR = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_RD,
      S_CHK,
      S_SWAP2,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [7:0]  kind;
      logic [7:0]  action;
      logic [15:0] tag;
      logic        keep;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] result_id;
      logic [6:0]  count;
      entry_type   entry;
   } result_type;

endpackage

@@ hw/rtl/reorderable_tagged_queue.sv @@
// Enqueue, clear and unknown commands complete in the dispatch state; a read
// of a valid position takes one store read. Remove, move up and move down scan
// the list one entry at a time, with a store read and a compare for each entry.
// Items are handled one at a time; a new word is taken while a result waits.
// Synchronous reset empties the list and sets the id counter to one;
// the entry store itself is not cleared.
module reorderable_tagged_queue #(
   parameter int DEPTH = rtq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_entry_id,
   input  logic [7:0]  req_change_kind,
   input  logic [7:0]  req_change_action,
   input  logic [15:0] req_payload_tag,
   input  logic        req_keep_going_flag,
   input  logic [5:0]  req_read_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [6:0]  rsp_entry_count,
   output logic [7:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_action,
   output logic [15:0] rsp_out_payload_tag,
   output logic        rsp_out_keep_going
);
   import rtq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic       done;
   logic       out_free;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   entry_type  mem_rd_data, mem_wr_data;

   rtq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_entry_id,
      .req_change_kind, .req_change_action, .req_payload_tag,
      .req_keep_going_flag, .req_read_position, .done, .out_free, .result,
      .mem_rd_en, .mem_rd_addr, .mem_rd_data, .mem_wr_en, .mem_wr_addr,
      .mem_wr_data
   );

   rtq_mem #(.DEPTH(DEPTH)) u_mem (
      .clock, .rd_en(mem_rd_en), .rd_addr(mem_rd_addr), .rd_data(mem_rd_data),
      .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data)
   );

   // output register: load a finished word when the slot is free
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (done && out_free) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_result_id       = rsp_ff.result_id;
   assign rsp_entry_count     = rsp_ff.count;
   assign rsp_out_kind        = rsp_ff.entry.kind;
   assign rsp_out_action      = rsp_ff.entry.action;
   assign rsp_out_payload_tag = rsp_ff.entry.tag;
   assign rsp_out_keep_going  = rsp_ff.entry.keep;
endmodule

@@ hw/rtl/rtq_mem.sv @@
// Entry store: one write port, one read port with registered read data.
module rtq_mem #(
   parameter int DEPTH = rtq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output rtq_pkg::entry_type rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  rtq_pkg::entry_type wr_data
);
   import rtq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/rtq_ctrl.sv @@
// Command sequencer: scans, compacts and swaps entries through the store.
module rtq_ctrl #(
   parameter int DEPTH = rtq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int IW    = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [31:0]        req_entry_id,
   input  logic [7:0]         req_change_kind,
   input  logic [7:0]         req_change_action,
   input  logic [15:0]        req_payload_tag,
   input  logic               req_keep_going_flag,
   input  logic [5:0]         req_read_position,
   output logic               done,
   input  logic               out_free,
   output rtq_pkg::result_type result,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  rtq_pkg::entry_type mem_rd_data,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output rtq_pkg::entry_type mem_wr_data
);
   import rtq_pkg::*;

   localparam int CW = (IW > 6) ? IW : 6;

   state_type  state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [31:0] id_ff, id_in;
   entry_type  new_ff, new_in;
   logic [5:0] pos_ff, pos_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] fill_ff, fill_in;
   logic [31:0] next_id_ff, next_id_in;
   logic       found_ff, found_in;
   entry_type  hold_ff, hold_in;
   result_type res_ff, res_in;

   logic [IW-1:0] idx_nx;
   logic          last;
   logic          hit;
   logic          pos_ok;
   logic          full;

   assign idx_nx = idx_ff + IW'(1);
   assign last   = !(idx_nx < fill_ff);
   assign hit    = (mem_rd_data.id == id_ff);
   assign pos_ok = CW'(pos_ff) < CW'(fill_ff);
   assign full   = (fill_ff == IW'(DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            case (cmd_ff)
               CMD_READ: state_in = pos_ok ? S_RD : S_DONE;
               CMD_REM, CMD_DOWN: state_in = (fill_ff != '0) ? S_RD : S_DONE;
               CMD_UP:   state_in = (fill_ff > IW'(1)) ? S_RD : S_DONE;
               default:  state_in = S_DONE;
            endcase
         end
         S_RD:       state_in = S_CHK;
         S_CHK: begin
            case (cmd_ff)
               CMD_UP:   state_in = (hit && idx_ff != '0) ? S_SWAP2 : (last ? S_DONE : S_RD);
               CMD_DOWN: state_in = found_ff ? S_SWAP2 : (last ? S_DONE : S_RD);
               CMD_REM:  state_in = last ? S_DONE : S_RD;
               default:  state_in = S_DONE;
            endcase
         end
         S_SWAP2:    state_in = S_DONE;
         S_DONE:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in      = cmd_ff;
      id_in       = id_ff;
      new_in      = new_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      fill_in     = fill_ff;
      next_id_in  = next_id_ff;
      found_in    = found_ff;
      hold_in     = hold_ff;
      res_in      = res_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(idx_ff - IW'(1));
      mem_wr_data = mem_rd_data;
      case (state_ff)
         S_IDLE: begin
            // capture the request word
            if (req_valid) begin
               cmd_in = req_command;
               id_in  = req_entry_id;
               new_in = '{id: 32'd0, kind: req_change_kind, action: req_change_action,
                          tag: req_payload_tag, keep: req_keep_going_flag};
               pos_in = req_read_position;
            end
         end
         S_DISPATCH: begin
            res_in        = '0;
            res_in.status = ST_MISS;
            found_in      = 1'b0;
            idx_in        = '0;
            case (cmd_ff)
               CMD_ENQ: begin
                  if (full) begin
                     res_in.status = ST_FULL;
                  end else begin
                     mem_wr_en      = 1'b1;
                     mem_wr_addr    = fill_ff[AW-1:0];
                     mem_wr_data    = new_ff;
                     mem_wr_data.id = next_id_ff;
                     res_in.status    = ST_OK;
                     res_in.result_id = next_id_ff;
                     next_id_in     = next_id_ff + 32'd1;
                     fill_in        = fill_ff + IW'(1);
                  end
               end
               CMD_CLEAR: begin
                  fill_in       = '0;
                  res_in.status = ST_OK;
               end
               CMD_READ: begin
                  if (pos_ok) idx_in = IW'(pos_ff);
                  else        res_in.status = ST_EMPTY;
               end
               default: ;
            endcase
         end
         S_RD: begin
            mem_rd_en = 1'b1;
         end
         S_CHK: begin
            if (!last) idx_in = idx_nx;
            case (cmd_ff)
               CMD_READ: begin
                  res_in.status    = ST_OK;
                  res_in.result_id = mem_rd_data.id;
                  res_in.entry     = mem_rd_data;
               end
               CMD_REM: begin
                  // shift entries behind the hit one place toward the head
                  if (found_ff) mem_wr_en = 1'b1;
                  found_in = found_ff | hit;
                  if (last && (found_ff || hit)) begin
                     fill_in       = fill_ff - IW'(1);
                     res_in.status = ST_OK;
                  end
               end
               CMD_UP: begin
                  if (hit && idx_ff != '0) begin
                     mem_wr_en     = 1'b1;
                     idx_in        = idx_ff;
                     res_in.status = ST_OK;
                  end else begin
                     hold_in = mem_rd_data;
                  end
               end
               CMD_DOWN: begin
                  if (found_ff) begin
                     mem_wr_en     = 1'b1;
                     idx_in        = idx_ff;
                     res_in.status = ST_OK;
                  end else if (hit) begin
                     found_in = 1'b1;
                     hold_in  = mem_rd_data;
                  end
               end
               default: ;
            endcase
         end
         S_SWAP2: begin
            // finish the swap with the held neighbor
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff[AW-1:0];
            mem_wr_data = hold_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         next_id_ff <= 32'd1;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         next_id_ff <= next_id_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      id_ff   <= id_in;
      new_ff  <= new_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      res_ff  <= res_in;
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      done         = (state_ff == S_DONE);
      result       = res_ff;
      result.count = 7'(fill_ff);
   end
endmodule

@@ hw/rtl/rtq_checker.sv @@
// Port-level checks for the reorderable tagged queue, bound to the top level.
module rtq_checker #(
   parameter int DEPTH = rtq_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_result_id,
   input logic [6:0]  rsp_entry_count,
   input logic [7:0]  rsp_out_kind
);
   import rtq_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown after reset");

   // a refused enqueue only happens on a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == 7'(DEPTH))
      else $error("full status with list not full");

   // an empty read returns no entry
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_result_id == 32'd0 && rsp_out_kind == 8'd0)
      else $error("empty read returned entry fields");
endmodule

bind reorderable_tagged_queue rtq_checker #(.DEPTH(DEPTH)) u_rtq_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_status,
   .rsp_result_id, .rsp_entry_count, .rsp_out_kind
);

@@ tb/sv/reorderable_tagged_queue_tb.sv @@
// Self-checking testbench for the reorderable tagged queue.
module reorderable_tagged_queue_tb;
   import rtq_pkg::*;

   localparam int QDEPTH = DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_id;
      logic [6:0]  count;
      logic [7:0]  kind;
      logic [7:0]  action;
      logic [15:0] tag;
      logic        keep;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = '0;
   logic [31:0] req_entry_id = '0;
   logic [7:0]  req_change_kind = '0;
   logic [7:0]  req_change_action = '0;
   logic [15:0] req_payload_tag = '0;
   logic        req_keep_going_flag = 1'b0;
   logic [5:0]  req_read_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_result_id;
   logic [6:0]  rsp_entry_count;
   logic [7:0]  rsp_out_kind;
   logic [7:0]  rsp_out_action;
   logic [15:0] rsp_out_payload_tag;
   logic        rsp_out_keep_going;

   // shadow list kept by the predictor
   logic [31:0] list_id [QDEPTH];
   logic [7:0]  list_kind [QDEPTH];
   logic [7:0]  list_action [QDEPTH];
   logic [15:0] list_tag [QDEPTH];
   logic        list_keep [QDEPTH];
   int          list_fill = 0;
   logic [31:0] id_counter = 32'd1;

   answer_type pending_answers [$];
   bit      failed = 1'b0;
   bit      idle_on = 1'b1;
   int      quiet_cycles = 0;

   reorderable_tagged_queue i_dut (.*);

   always #2 clock = ~clock;

   // swap two shadow positions
   task automatic swap_pos(input int a, input int b);
      logic [31:0] t_id;
      logic [7:0]  t_kind, t_act;
      logic [15:0] t_tag;
      logic        t_keep;
      t_id = list_id[a]; t_kind = list_kind[a]; t_act = list_action[a];
      t_tag = list_tag[a]; t_keep = list_keep[a];
      list_id[a] = list_id[b]; list_kind[a] = list_kind[b];
      list_action[a] = list_action[b]; list_tag[a] = list_tag[b];
      list_keep[a] = list_keep[b];
      list_id[b] = t_id; list_kind[b] = t_kind; list_action[b] = t_act;
      list_tag[b] = t_tag; list_keep[b] = t_keep;
   endtask

   function automatic int find_id(input int start, input logic [31:0] id);
      for (int i = start; i < list_fill; i++)
         if (list_id[i] == id) return i;
      return list_fill;
   endfunction

   // work out the answer to one command and update the shadow list
   task automatic predict_command(input logic [2:0] cmd, input logic [31:0] id,
                                  input logic [7:0] kind, input logic [7:0] act,
                                  input logic [15:0] tag, input logic keep,
                                  input logic [5:0] pos);
      answer_type a;
      int      p;
      a = '0;
      a.status = ST_MISS;
      case (cmd)
         CMD_ENQ: begin
            if (list_fill >= QDEPTH) begin
               a.status = ST_FULL;
            end else begin
               list_id[list_fill] = id_counter; list_kind[list_fill] = kind;
               list_action[list_fill] = act; list_tag[list_fill] = tag;
               list_keep[list_fill] = keep;
               a.result_id = id_counter;
               id_counter = id_counter + 32'd1;
               list_fill++;
               a.status = ST_OK;
            end
         end
         CMD_REM: begin
            p = find_id(0, id);
            if (p < list_fill) begin
               for (int i = p; i + 1 < list_fill; i++) begin
                  list_id[i] = list_id[i+1]; list_kind[i] = list_kind[i+1];
                  list_action[i] = list_action[i+1]; list_tag[i] = list_tag[i+1];
                  list_keep[i] = list_keep[i+1];
               end
               list_fill--;
               a.status = ST_OK;
            end
         end
         CMD_UP: begin
            p = find_id(1, id);
            if (p < list_fill) begin
               swap_pos(p, p - 1);
               a.status = ST_OK;
            end
         end
         CMD_DOWN: begin
            p = find_id(0, id);
            if (p + 1 < list_fill) begin
               swap_pos(p, p + 1);
               a.status = ST_OK;
            end
         end
         CMD_CLEAR: begin
            list_fill = 0;
            a.status = ST_OK;
         end
         CMD_READ: begin
            if (pos < list_fill) begin
               a.result_id = list_id[pos]; a.kind = list_kind[pos];
               a.action = list_action[pos]; a.tag = list_tag[pos];
               a.keep = list_keep[pos];
               a.status = ST_OK;
            end else begin
               a.status = ST_EMPTY;
            end
         end
         default: a.status = ST_MISS;
      endcase
      a.count = 7'(list_fill);
      pending_answers = {pending_answers, a};
   endtask

   // send one word; the prediction is made when it is accepted
   task automatic send_word(input logic [2:0] cmd, input logic [31:0] id,
                            input logic [7:0] kind, input logic [7:0] act,
                            input logic [15:0] tag, input logic keep,
                            input logic [5:0] pos);
      if (idle_on && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1; req_command <= cmd; req_entry_id <= id;
      req_change_kind <= kind; req_change_action <= act;
      req_payload_tag <= tag; req_keep_going_flag <= keep;
      req_read_position <= pos;
      do @(posedge clock); while (!req_ready);
      predict_command(cmd, id, kind, act, tag, keep, pos);
      @(negedge clock);
   endtask

   task automatic send_rand_enq();
      send_word(CMD_ENQ, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                1'($urandom), 6'($urandom));
   endtask

   // pick an id: mostly present ones, sometimes arbitrary
   function automatic logic [31:0] pick_id();
      if (list_fill > 0 && $urandom_range(4) != 0)
         return list_id[$urandom_range(list_fill - 1)];
      return $urandom;
   endfunction

   // compare each result with the oldest answer
   always @(posedge clock) begin
      answer_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         quiet_cycles <= 0;
         got = {rsp_status, rsp_result_id, rsp_entry_count, rsp_out_kind,
                rsp_out_action, rsp_out_payload_tag, rsp_out_keep_going};
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            failed = 1'b1;
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               failed = 1'b1;
            end
         end
      end else if (!reset && req_valid && req_ready) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // drive the result-side stalls in bursts
   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("reorderable_tagged_queue_tb: FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      send_word(CMD_READ, '0, '0, '0, '0, '0, 6'd0);
      send_word(CMD_REM, 32'd1, '0, '0, '0, '0, '0);
      send_word(CMD_ENQ, '0, 8'hFF, 8'h00, 16'hFFFF, 1'b1, '0);
      send_word(CMD_ENQ, 32'hFFFF_FFFF, 8'h00, 8'hFF, 16'h0000, 1'b0, 6'h3F);
      send_word(CMD_ENQ, '0, 8'hA5, 8'h5A, 16'h1234, 1'b1, '0);
      send_word(CMD_UP, 32'd1, '0, '0, '0, '0, '0);      // head cannot rise
      send_word(CMD_DOWN, 32'd3, '0, '0, '0, '0, '0);    // tail cannot sink
      send_word(CMD_UP, 32'd3, '0, '0, '0, '0, '0);
      send_word(CMD_DOWN, 32'd1, '0, '0, '0, '0, '0);
      send_word(CMD_UP, 32'hDEAD_BEEF, '0, '0, '0, '0, '0);
      send_word(3'd6, '0, '0, '0, '0, '0, '0);
      send_word(3'd7, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 6'h3F);
      for (int i = 0; i < 3; i++) send_word(CMD_READ, '0, '0, '0, '0, '0, 6'(i));
      send_word(CMD_READ, '0, '0, '0, '0, '0, 6'h3F);
      send_word(CMD_REM, 32'd3, '0, '0, '0, '0, '0);
      send_word(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
      send_word(CMD_READ, '0, '0, '0, '0, '0, 6'd0);
   endtask

   // fill to the brim, refuse one, read the top, try to move the tail down and up, and empty by removing picked ids
   task automatic test_full_list();
      while (list_fill < QDEPTH) send_rand_enq();
      send_rand_enq();
      send_word(CMD_READ, '0, '0, '0, '0, '0, 6'h3F);
      send_word(CMD_DOWN, list_id[QDEPTH-1], '0, '0, '0, '0, '0);
      send_word(CMD_UP, list_id[QDEPTH-1], '0, '0, '0, '0, '0);
      while (list_fill > 0) send_word(CMD_REM, pick_id(), '0, '0, '0, '0, '0);
   endtask

   // random mix of commands weighted toward well-formed ones
   task automatic test_random(input int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 35 && list_fill < QDEPTH) send_rand_enq();
         else if (r < 50) send_word(CMD_REM, pick_id(), '0, '0, '0, '0, '0);
         else if (r < 62) send_word(CMD_UP, pick_id(), '0, '0, '0, '0, '0);
         else if (r < 74) send_word(CMD_DOWN, pick_id(), '0, '0, '0, '0, '0);
         else if (r < 95)
            send_word(CMD_READ, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                      1'($urandom),
                      $urandom_range(1) ? 6'($urandom_range(list_fill)) : 6'($urandom));
         else if (r < 97) send_word(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
         else send_word(3'($urandom_range(6, 7)), $urandom, '0, '0, '0, '0, '0);
      end
   endtask

   // jump the id counter near its wrap by cycling enqueue/clear is too slow,
   // so the run does not reach id wrap and every id handed out stays unique
   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_list();
      test_random(1300);
      idle_on = 1'b0;
      test_random(150);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed)
         $display("reorderable_tagged_queue_tb: PASS");
      else
         $display("reorderable_tagged_queue_tb: FAIL");
      $finish;
   end

endmodule
